// ===== design/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define AST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define AST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/ast_pkg.sv =====
// Package for the argument string tokenizer: widths, character codes,
// result kinds, status codes and the structs passed between modules.
// No dependencies.
package ast_pkg;

  localparam int CHAR_W = 8;
  localparam int CNT_W  = 6;

  // Highest argument count, program name included.
  localparam logic [CNT_W-1:0] ARG_LIMIT = 6'd32;

  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

  localparam logic [CHAR_W-1:0] STATUS_SUCCESS    = 8'd0;
  localparam logic [CHAR_W-1:0] STATUS_TOO_MANY   = 8'd1;
  localparam logic [CHAR_W-1:0] STATUS_OPEN_QUOTE = 8'd2;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_END    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } quote_e;

  typedef struct packed {
    quote_e           qmode;
    logic             in_tok;
    logic             esc;
    logic [CNT_W-1:0] cnt;
    logic             err;
  } ast_state_t;

  localparam ast_state_t STATE_RESET = '{
    qmode:  QUOTE_NONE,
    in_tok: 1'b0,
    esc:    1'b0,
    cnt:    6'd1,
    err:    1'b0
  };

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] value;
  } ast_res_t;

  // All results caused by one input byte; slot 0 leaves first.
  typedef struct packed {
    logic [1:0]         num;
    ast_res_t [2:0]     res;
    logic [CNT_W-1:0]   count;
  } ast_bundle_t;

  function automatic logic is_sep(input logic [CHAR_W-1:0] c);
    logic r;
    case (c) inside
      CH_SPACE, CH_TAB, CH_CR, CH_LF: r = 1'b1;
      default:                        r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/ast_if.sv =====
// Stream interfaces of the argument string tokenizer: one for text bytes,
// one for results. Depends on ast_pkg.
interface ast_in_if import ast_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface ast_out_if import ast_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [CHAR_W-1:0] value;
  logic [CNT_W-1:0]  arg_count;
  logic              last_of_run;

  modport source (output valid, output kind, output value, output arg_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input value, input arg_count,
                  input last_of_run, output ready);
endinterface

// ===== design/ast_parse.sv =====
// Per-byte tokenizer step: next state and the bundle of results for one item.
// Purely combinational. Depends on ast_pkg.
module ast_parse import ast_pkg::*; (
  input  ast_state_t        state_i,
  input  logic [CHAR_W-1:0] ch_i,
  input  logic              end_of_text_i,
  output ast_state_t        state_o,
  output ast_bundle_t       bundle_o
);

  ast_state_t        st;
  ast_bundle_t       bun;
  logic [1:0]        n;
  logic [CHAR_W-1:0] qch;

  always_comb begin
    st  = state_i;
    bun = '0;
    n   = 2'd0;
    qch = (state_i.qmode == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
    bun.count = state_i.cnt;

    if (end_of_text_i) begin
      // The end marker always returns to the reset state.
      if (!state_i.err) begin
        if (state_i.esc) begin
          bun.res[n] = '{kind: KIND_BYTE, value: CH_BSLASH};
          n = n + 2'd1;
        end
        if (state_i.qmode != QUOTE_NONE) begin
          bun.res[n] = '{kind: KIND_STATUS, value: STATUS_OPEN_QUOTE};
          n = n + 2'd1;
        end else begin
          if (state_i.in_tok) begin
            bun.res[n] = '{kind: KIND_END, value: '0};
            n = n + 2'd1;
          end
          bun.res[n] = '{kind: KIND_STATUS, value: STATUS_SUCCESS};
          n = n + 2'd1;
        end
      end
      st = STATE_RESET;
    end else if (!state_i.err) begin
      if (state_i.esc) begin
        st.esc = 1'b0;
        bun.res[n] = '{kind: KIND_BYTE, value: ch_i};
        n = n + 2'd1;
      end else if (state_i.qmode != QUOTE_NONE) begin
        if (ch_i == qch) begin
          st.qmode = QUOTE_NONE;
        end else if (ch_i == CH_BSLASH) begin
          st.esc = 1'b1;
        end else begin
          bun.res[n] = '{kind: KIND_BYTE, value: ch_i};
          n = n + 2'd1;
        end
      end else if (is_sep(ch_i)) begin
        if (state_i.in_tok) begin
          st.in_tok = 1'b0;
          bun.res[n] = '{kind: KIND_END, value: '0};
          n = n + 2'd1;
        end
      end else if (!state_i.in_tok && (state_i.cnt >= ARG_LIMIT)) begin
        // A new token past the limit ends the string with an error.
        st.err = 1'b1;
        bun.res[n] = '{kind: KIND_STATUS, value: STATUS_TOO_MANY};
        n = n + 2'd1;
      end else begin
        if (!state_i.in_tok) begin
          st.in_tok = 1'b1;
          st.cnt    = state_i.cnt + 6'd1;
        end
        if (ch_i == CH_SQUOTE) begin
          st.qmode = QUOTE_SINGLE;
        end else if (ch_i == CH_DQUOTE) begin
          st.qmode = QUOTE_DOUBLE;
        end else if (ch_i == CH_BSLASH) begin
          st.esc = 1'b1;
        end else begin
          bun.res[n] = '{kind: KIND_BYTE, value: ch_i};
          n = n + 2'd1;
        end
      end
    end
    bun.num  = n;
    state_o  = st;
    bundle_o = bun;
  end

endmodule

// ===== design/argument_string_tokenizer.sv =====
// Top level of the argument string tokenizer: parser state, a two-entry
// result buffer and the result serializer. Depends on ast_pkg, ast_if, ast_parse.
// A byte request is taken in any cycle in which the result buffer has a free
// entry, so a stream whose results are taken promptly runs at one byte per
// clock. Each byte yields zero to three results (token bytes, token ends and a
// final status), which leave on the output one per cycle while out_o.ready is
// high, so the output port sets the sustained rate: a byte with k results holds
// it until all have left, and the two buffered groups absorb the difference.
module argument_string_tokenizer import ast_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ast_in_if.sink    in_i,
  ast_out_if.source out_o
);

`include "assert_macros.svh"

  // Parser state, updated once per accepted byte request.
  ast_state_t  state_q;
  ast_state_t  state_d;
  ast_bundle_t bun_d;

  // Two result groups in a small ring; idx_q walks the results of the head.
  ast_bundle_t bun_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  fill_q;
  logic [1:0]  idx_q;

  logic        in_acc;
  logic        out_acc;
  logic        push;
  logic        pop;
  ast_bundle_t head;
  ast_res_t    head_res;
  logic        head_last;

  ast_parse u_parse (
    .state_i       (state_q),
    .ch_i          (in_i.ch),
    .end_of_text_i (in_i.end_of_text),
    .state_o       (state_d),
    .bundle_o      (bun_d)
  );

  // The input side only looks at buffer occupancy, so it never waits on the
  // output side combinationally.
  assign in_i.ready = (fill_q != 2'd2);
  assign in_acc     = in_i.valid & in_i.ready;
  // Bytes that cause no result leave nothing in the buffer.
  assign push       = in_acc & (bun_d.num != 2'd0);

  assign head      = bun_q[rd_ptr_q];
  assign head_res  = head.res[idx_q];
  assign head_last = (idx_q == (head.num - 2'd1));

  assign out_o.valid       = (fill_q != 2'd0);
  assign out_o.kind        = head_res.kind;
  assign out_o.value       = head_res.value;
  assign out_o.arg_count   = (head_res.kind == KIND_STATUS) ? head.count : '0;
  assign out_o.last_of_run = head_last;

  assign out_acc = out_o.valid & out_o.ready;
  assign pop     = out_acc & head_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
      idx_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
      if (out_acc) begin
        idx_q <= head_last ? 2'd0 : (idx_q + 2'd1);
      end
    end
  end

  // Result payload holds no control information and needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      bun_q[wr_ptr_q] <= bun_d;
    end
  end

  `AST_ASSERT(a_fill_range, fill_q != 2'd3, "result buffer overfilled")
  `AST_ASSERT_SAME(a_idx_in_group, out_o.valid, idx_q < head.num, "result index past group")
  `AST_ASSERT_SAME(a_status_last, out_o.valid && (head_res.kind == KIND_STATUS),
                   head_last, "final status is not the last result of its byte")
  `AST_ASSERT_NEXT(a_end_resets, in_acc && in_i.end_of_text,
                   state_q == STATE_RESET, "end of text did not restore the reset state")
  `AST_ASSERT_SAME(a_err_silent, in_acc && state_q.err && !in_i.end_of_text,
                   bun_d.num == 2'd0, "results produced after an error")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the argument string tokenizer: random and directed argument strings,
// each result checked against a cycle-free prediction of the token stream.
// Depends on ast_pkg, ast_if and the argument_string_tokenizer RTL.
module tb_top;
  import ast_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              eot;
  } text_req_t;

  typedef struct {
    kind_e             kind;
    logic [CHAR_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic              last_of_run;
  } split_res_t;

  logic clk_i;
  logic rst_ni;

  ast_in_if  text_if ();
  ast_out_if result_if ();

  argument_string_tokenizer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (text_if),
    .out_o  (result_if)
  );

  // Text requests still to be sent, and the results the splitter should produce.
  text_req_t  arg_text[$];
  split_res_t split_results[$];

  // Predicted splitter state.
  quote_e           tk_quote;
  logic             tk_in_token;
  logic             tk_escape;
  logic             tk_error;
  logic [CNT_W-1:0] tk_count;

  int bytes_sent;
  int strings_sent;
  int results_checked;
  int mismatches;

  int         send_gap;
  bit         send_calm;
  int         take_gap;
  bit         take_calm;
  text_req_t  next_req;
  split_res_t want;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic split_res_t result_of(input kind_e k, input logic [CHAR_W-1:0] v,
                                           input logic [CNT_W-1:0] n);
    split_res_t r;
    r.kind        = k;
    r.value       = v;
    r.count       = n;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic void clear_tokenizer();
    tk_quote    = QUOTE_NONE;
    tk_in_token = 1'b0;
    tk_escape   = 1'b0;
    tk_error    = 1'b0;
    tk_count    = 6'd1;
  endfunction

  // Works out the results of one accepted text request and queues them,
  // marking the last one of the group.
  task automatic split_step(input logic [CHAR_W-1:0] c, input logic eot);
    split_res_t       run[$];
    logic [CHAR_W-1:0] closing;
    if (eot) begin
      // After too many arguments the end marker only clears the state.
      if (!tk_error) begin
        if (tk_escape) run.push_back(result_of(KIND_BYTE, CH_BSLASH, '0));
        if (tk_quote != QUOTE_NONE) begin
          run.push_back(result_of(KIND_STATUS, STATUS_OPEN_QUOTE, tk_count));
        end else begin
          if (tk_in_token) run.push_back(result_of(KIND_END, '0, '0));
          run.push_back(result_of(KIND_STATUS, STATUS_SUCCESS, tk_count));
        end
      end
      clear_tokenizer();
    end else if (!tk_error) begin
      if (tk_escape) begin
        tk_escape = 1'b0;
        run.push_back(result_of(KIND_BYTE, c, '0));
      end else if (tk_quote != QUOTE_NONE) begin
        closing = (tk_quote == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
        if (c == closing) tk_quote = QUOTE_NONE;
        else if (c == CH_BSLASH) tk_escape = 1'b1;
        else run.push_back(result_of(KIND_BYTE, c, '0));
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
        if (tk_in_token) begin
          tk_in_token = 1'b0;
          run.push_back(result_of(KIND_END, '0, '0));
        end
      end else if (!tk_in_token && tk_count >= ARG_LIMIT) begin
        tk_error = 1'b1;
        run.push_back(result_of(KIND_STATUS, STATUS_TOO_MANY, tk_count));
      end else begin
        if (!tk_in_token) begin
          tk_in_token = 1'b1;
          tk_count    = tk_count + 6'd1;
        end
        if (c == CH_SQUOTE) tk_quote = QUOTE_SINGLE;
        else if (c == CH_DQUOTE) tk_quote = QUOTE_DOUBLE;
        else if (c == CH_BSLASH) tk_escape = 1'b1;
        else run.push_back(result_of(KIND_BYTE, c, '0));
      end
    end
    if (run.size() > 0) begin
      run[run.size()-1].last_of_run = 1'b1;
      foreach (run[i]) split_results.push_back(run[i]);
    end
  endtask

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int idle_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  task automatic push_byte(input logic [CHAR_W-1:0] c);
    text_req_t t;
    t.ch  = c;
    t.eot = 1'b0;
    arg_text.push_back(t);
  endtask

  // The byte lane of an end marker is don't-care, so it carries noise.
  task automatic push_end();
    text_req_t t;
    t.ch  = 8'($urandom_range(0, 255));
    t.eot = 1'b1;
    arg_text.push_back(t);
  endtask

  function automatic logic [CHAR_W-1:0] sep_char();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] special_char();
    case ($urandom_range(0, 3))
      0:       return sep_char();
      1:       return CH_SQUOTE;
      2:       return CH_DQUOTE;
      default: return CH_BSLASH;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
           c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BSLASH)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] quoted_char(input logic [CHAR_W-1:0] closing);
    logic [CHAR_W-1:0] c;
    c = ($urandom_range(0, 3) == 0) ? special_char() : 8'($urandom_range(0, 255));
    while (c == closing || c == CH_BSLASH) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // One argument string of ntok tokens with random content. In terse mode every
  // token is a single plain byte behind a single separator, so long strings
  // stay short in requests.
  task automatic add_command_line(input int ntok, input bit terse);
    int               pieces;
    int               piece_sel;
    logic [CHAR_W-1:0] closing;
    if ($urandom_range(0, 1)) push_byte(sep_char());
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) repeat (terse ? 1 : $urandom_range(1, 2)) push_byte(sep_char());
      pieces = terse ? 1 : $urandom_range(1, 3);
      repeat (pieces) begin
        piece_sel = terse ? 0 : $urandom_range(0, 3);
        case (piece_sel)
          0: repeat (terse ? 1 : $urandom_range(1, 3)) push_byte(plain_char());
          1, 2: begin
            closing = (piece_sel == 1) ? CH_SQUOTE : CH_DQUOTE;
            push_byte(closing);
            repeat ($urandom_range(0, 3)) begin
              if ($urandom_range(0, 4) == 0) begin
                push_byte(CH_BSLASH);
                push_byte(8'($urandom_range(0, 255)));
              end else begin
                push_byte(quoted_char(closing));
              end
            end
            push_byte(closing);
          end
          default: begin
            push_byte(CH_BSLASH);
            push_byte(8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
    // Occasionally end on an open quote, a lone backslash or trailing blanks.
    if (!terse) begin
      case ($urandom_range(0, 7))
        0: begin
          push_byte($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
          repeat ($urandom_range(0, 2)) push_byte(plain_char());
          if ($urandom_range(0, 1)) push_byte(CH_BSLASH);
        end
        1:       push_byte(CH_BSLASH);
        2, 3:    push_byte(sep_char());
        default: ;
      endcase
    end
    push_end();
  endtask

  initial begin
    int r;
    clear_tokenizer();

    // Empty text, then blank text made of every separator.
    push_end();
    push_byte(CH_SPACE);
    push_byte(CH_TAB);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_end();
    // A zero byte and an all-ones byte are ordinary token bytes.
    push_byte(8'h61);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_end();
    // Single-quoted group holding a blank and an escaped quote, then a
    // double-quoted token.
    push_byte(CH_SQUOTE);
    push_byte(CH_SPACE);
    push_byte(CH_BSLASH);
    push_byte(CH_SQUOTE);
    push_byte(CH_SQUOTE);
    push_byte(CH_SPACE);
    push_byte(CH_DQUOTE);
    push_byte(8'h71);
    push_byte(CH_DQUOTE);
    push_end();
    // A backslash as the very last byte stays literal.
    push_byte(CH_BSLASH);
    push_end();
    // A double quote left open with an escape pending at the end.
    push_byte(CH_DQUOTE);
    push_byte(8'h7A);
    push_byte(CH_BSLASH);
    push_end();

    // Exactly at the argument limit, then three tokens past it so the rest of the
    // string, end marker included, is swallowed.
    add_command_line(int'(ARG_LIMIT) - 1, 1'b1);
    add_command_line(int'(ARG_LIMIT) + 2, 1'b1);

    // Mostly well-formed strings with random content, some raw noise.
    while (arg_text.size() < 250) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        add_command_line($urandom_range(0, 5), 1'b0);
      end else begin
        repeat ($urandom_range(1, 8))
          push_byte($urandom_range(0, 1) ? special_char() : 8'($urandom_range(0, 255)));
        push_end();
      end
    end

    @(posedge rst_ni);
    while (arg_text.size() != 0 || text_if.valid) @(posedge clk_i);
    while (split_results.size() != 0) @(posedge clk_i);
    // Leave room for any stray result to show up.
    repeat (20) @(posedge clk_i);

    $display("Summary: %0d text requests in %0d argument strings, %0d results checked.",
             bytes_sent, strings_sent, results_checked);
    $display("Summary: %0d mismatching or unexpected results.", mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Driver: presents the pending text requests, with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_if.valid       <= 1'b0;
      text_if.ch          <= '0;
      text_if.end_of_text <= 1'b0;
      send_gap = 0;
    end else begin
      if (text_if.valid && text_if.ready) begin
        split_step(text_if.ch, text_if.end_of_text);
        bytes_sent++;
        if (text_if.end_of_text) strings_sent++;
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
        send_gap = idle_len(send_calm);
      end
      if (!text_if.valid || text_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          text_if.valid <= 1'b0;
        end else if (arg_text.size() > 0) begin
          next_req = arg_text.pop_front();
          text_if.valid       <= 1'b1;
          text_if.ch          <= next_req.ch;
          text_if.end_of_text <= next_req.eot;
        end else begin
          text_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(input string what);
    if (mismatches < 10) begin
      $display("%0t: %s: got kind=%0d value=%02h count=%0d last=%0b", $realtime, what,
               result_if.kind, result_if.value, result_if.arg_count, result_if.last_of_run);
    end
    mismatches++;
  endtask

  // Monitor: takes results with random stalls and compares each one with the
  // oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (split_results.size() == 0) begin
          note_mismatch("Result with nothing expected");
        end else begin
          want = split_results.pop_front();
          if (result_if.kind !== want.kind || result_if.value !== want.value ||
              result_if.arg_count !== want.count ||
              result_if.last_of_run !== want.last_of_run) begin
            if (mismatches < 10) begin
              $display("%0t: expected kind=%0d value=%02h count=%0d last=%0b", $realtime,
                       want.kind, want.value, want.count, want.last_of_run);
            end
            note_mismatch("Result differs");
          end
          results_checked++;
        end
        if ($urandom_range(0, 29) == 0) take_calm = !take_calm;
        take_gap = idle_len(take_calm);
      end
      result_if.ready <= (take_gap == 0);
      if (take_gap > 0) take_gap--;
    end
  end

endmodule
